>>> hw/rtl/stepped_speed_regulator_pwm_core_assert.svh
// assertion macros shared by the checker
`ifndef STEPPED_SPEED_REGULATOR_PWM_CORE_ASSERT_SVH
`define STEPPED_SPEED_REGULATOR_PWM_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SSPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sspr_pkg.sv
package sspr_pkg;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_SPEED_PER_PULSE = 3'd0;
	localparam logic [2:0] REG_DUTY_PER_SPEED  = 3'd1;
	localparam logic [2:0] REG_ANGLE_GAIN      = 3'd2;
	localparam logic [2:0] REG_CMD_INC         = 3'd3;
	localparam logic [2:0] REG_SEEN_TOL        = 3'd4;
	localparam logic [2:0] REG_NEUTRAL_DUTY    = 3'd5;
	localparam logic [2:0] REG_DUTY_SPAN       = 3'd6;

	// duty update codes from the controller to the duty stage
	localparam logic [1:0] DUTY_HOLD    = 2'd0;
	localparam logic [1:0] DUTY_DRIVE   = 2'd1;
	localparam logic [1:0] DUTY_NEUTRAL = 2'd2;

	localparam logic [10:0] NEUTRAL_RESET = 11'd1500;
	localparam logic [17:0] MAG_LIMIT     = 18'd131072;
	localparam int          OUT_W         = 40;

	typedef struct packed {
		logic [9:0]  speed_per_pulse;
		logic [15:0] duty_per_speed;
		logic [15:0] angle_gain;
		logic [10:0] cmd_inc;
		logic [10:0] seen_tol;
		logic [10:0] neutral_duty;
		logic [9:0]  duty_span;
	} cfg_t;

	typedef struct packed {
		logic signed [12:0] target_speed;
		logic signed [5:0]  target_angle;
		logic [17:0]        mag;
		logic               pulses_zero;
		logic               stop_request;
	} meas_t;

	typedef struct packed {
		logic [1:0]         mot_mode;
		logic [1:0]         srv_mode;
		logic signed [15:0] cmd;
		logic signed [5:0]  angle;
		logic signed [17:0] speed_seen;
	} ctrl_t;

	// neutral plus offset, offset clamped to the span, result saturated to 11 bits
	function automatic logic [10:0] duty_of(input logic [15:0] mag, input logic neg,
			input logic [10:0] neutral, input logic [9:0] span);
		logic [9:0]  off;
		logic [11:0] sum;
		logic [11:0] dif;
		off = (mag > {6'd0, span}) ? span : mag[9:0];
		sum = {1'b0, neutral} + {2'b00, off};
		dif = {1'b0, neutral} - {2'b00, off};
		if (neg) begin
			duty_of = dif[11] ? 11'd0 : dif[10:0];
		end else begin
			duty_of = sum[11] ? 11'd2047 : sum[10:0];
		end
	endfunction

endpackage

>>> hw/rtl/sspr_meas.sv
module sspr_meas #(
	parameter int PULSE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   load,
	input  logic [9:0]             speed_per_pulse,
	input  logic signed [12:0]     target_speed,
	input  logic signed [5:0]      target_angle,
	input  logic [PULSE_BITS-1:0]  pulse_count,
	input  logic                   stop_request,
	output sspr_pkg::meas_t        meas_s2
);
	import sspr_pkg::*;

	localparam int MW = 10 + PULSE_BITS;
	localparam int XW = (MW > 18) ? MW : 18;

	logic [MW-1:0] prod;
	logic [XW-1:0] prod_x;
	logic [17:0]   mag;

	// pulse product, limited to the largest magnitude the reverse direction can show
	assign prod   = MW'(speed_per_pulse) * MW'(pulse_count);
	assign prod_x = XW'(prod);
	assign mag    = (prod_x > XW'(MAG_LIMIT)) ? MAG_LIMIT : prod_x[17:0];

	always_ff @(posedge clk) begin
		if (load) begin
			meas_s2.target_speed <= target_speed;
			meas_s2.target_angle <= target_angle;
			meas_s2.mag          <= mag;
			meas_s2.pulses_zero  <= (pulse_count == '0);
			meas_s2.stop_request <= stop_request;
		end
	end

endmodule

>>> hw/rtl/sspr_ctrl.sv
module sspr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            upd,
	input  sspr_pkg::cfg_t  cfg,
	input  sspr_pkg::meas_t meas,
	output sspr_pkg::ctrl_t ctrl_s3
);
	import sspr_pkg::*;

	logic signed [12:0] last_target_q;
	logic signed [15:0] speed_command_q;
	logic signed [17:0] speed_seen_q;
	logic               reverse_dir_q;
	logic               hold_q;
	logic signed [5:0]  last_angle_q;

	logic signed [12:0] tgt;
	logic               case_rev, case_same, run_reg, tgt_zero;
	logic signed [12:0] lt_in;
	logic               hold_in, seen0_zero;
	logic signed [15:0] cmd_base;
	logic signed [17:0] seen_m;
	logic signed [18:0] neg_mag;
	logic signed [18:0] diff;
	logic [18:0]        diff_abs;
	logic               reached;
	logic signed [17:0] cmd_wide;
	logic signed [15:0] cmd_step;

	logic signed [12:0] lt_d;
	logic signed [15:0] cmd_d;
	logic signed [17:0] seen_d;
	logic               rev_d, hold_d;
	logic signed [5:0]  la_d;
	ctrl_t              ctrl_d;

	always_comb begin
		tgt        = meas.target_speed;
		case_rev   = (speed_seen_q > 18'sd0) && tgt[12];
		case_same  = !case_rev && (last_target_q == tgt);
		run_reg    = case_rev || case_same;
		tgt_zero   = (tgt == 13'sd0);
		lt_in      = case_rev ? 13'sd0 : last_target_q;
		hold_in    = case_rev || hold_q;
		seen0_zero = meas.pulses_zero || (speed_seen_q == 18'sd0);

		// command reload when no speed was seen
		if (!seen0_zero) begin
			cmd_base = speed_command_q;
		end else if (hold_in) begin
			cmd_base = $signed({{3{lt_in[12]}}, lt_in});
		end else begin
			cmd_base = $signed({{3{tgt[12]}}, tgt});
		end

		neg_mag = -$signed({1'b0, meas.mag});
		if (reverse_dir_q) begin
			seen_m = neg_mag[17:0];
		end else begin
			seen_m = meas.mag[17] ? 18'sh1FFFF : $signed(meas.mag);
		end

		diff     = $signed({{6{tgt[12]}}, tgt}) - $signed({seen_m[17], seen_m});
		diff_abs = diff[18] ? 19'(-diff) : 19'(diff);
		reached  = (reverse_dir_q && (lt_in == 13'sd0)) || (diff_abs <= {8'd0, cfg.seen_tol});

		cmd_wide = $signed({{2{cmd_base[15]}}, cmd_base});
		if (diff[18]) begin
			cmd_wide = cmd_wide - $signed({7'd0, cfg.cmd_inc});
		end else if (diff != 19'sd0) begin
			cmd_wide = cmd_wide + $signed({7'd0, cfg.cmd_inc});
		end
		if (cmd_wide > 18'sd32767) begin
			cmd_step = 16'sh7FFF;
		end else if (cmd_wide < -18'sd32768) begin
			cmd_step = 16'sh8000;
		end else begin
			cmd_step = cmd_wide[15:0];
		end

		lt_d            = tgt;
		cmd_d           = speed_command_q;
		seen_d          = speed_seen_q;
		rev_d           = reverse_dir_q;
		hold_d          = hold_q;
		la_d            = last_angle_q;
		ctrl_d.mot_mode = DUTY_HOLD;
		ctrl_d.srv_mode = DUTY_HOLD;

		if (meas.stop_request) begin
			lt_d            = 13'sd0;
			cmd_d           = 16'sd0;
			seen_d          = 18'sd0;
			rev_d           = 1'b0;
			hold_d          = 1'b0;
			la_d            = 6'sd0;
			ctrl_d.mot_mode = DUTY_NEUTRAL;
			ctrl_d.srv_mode = DUTY_NEUTRAL;
		end else begin
			if (run_reg) begin
				seen_d = seen_m;
				hold_d = hold_in && !seen0_zero;
				if (tgt_zero) begin
					// zero target: back to neutral
					cmd_d           = 16'sd0;
					rev_d           = 1'b0;
					la_d            = 6'sd0;
					ctrl_d.mot_mode = DUTY_NEUTRAL;
					ctrl_d.srv_mode = DUTY_NEUTRAL;
				end else if (reached) begin
					cmd_d = cmd_base;
				end else begin
					cmd_d           = cmd_step;
					ctrl_d.mot_mode = DUTY_DRIVE;
				end
			end else begin
				// new target: drive the held command, take the new direction
				rev_d           = tgt[12];
				ctrl_d.mot_mode = DUTY_DRIVE;
			end
			if (meas.target_angle != la_d) begin
				la_d            = meas.target_angle;
				ctrl_d.srv_mode = DUTY_DRIVE;
			end
		end

		ctrl_d.cmd        = cmd_d;
		ctrl_d.angle      = meas.target_angle;
		ctrl_d.speed_seen = seen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_target_q   <= '0;
			speed_command_q <= '0;
			speed_seen_q    <= '0;
			reverse_dir_q   <= 1'b0;
			hold_q          <= 1'b0;
			last_angle_q    <= '0;
		end else if (upd) begin
			last_target_q   <= lt_d;
			speed_command_q <= cmd_d;
			speed_seen_q    <= seen_d;
			reverse_dir_q   <= rev_d;
			hold_q          <= hold_d;
			last_angle_q    <= la_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctrl_s3 <= ctrl_d;
		end
	end

endmodule

>>> hw/rtl/sspr_duty.sv
module sspr_duty (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sspr_pkg::cfg_t     cfg,
	input  sspr_pkg::ctrl_t    ctrl,
	output logic [10:0]        motor_duty_q,
	output logic [10:0]        servo_duty_q,
	output logic signed [17:0] measured_speed_q
);
	import sspr_pkg::*;

	logic [16:0] cmd_mag;
	logic [32:0] mot_prod;
	logic [32:0] mot_rnd;
	logic [5:0]  ang_mag;
	logic [21:0] srv_prod;
	logic [21:0] srv_rnd;
	logic [10:0] mot_drive, srv_drive;
	logic [10:0] mot_d, srv_d;

	// round half away from zero on the magnitude, sign restored by the clamp
	assign cmd_mag   = ctrl.cmd[15] ? 17'(-{ctrl.cmd[15], ctrl.cmd})
	                                : {1'b0, ctrl.cmd};
	assign mot_prod  = 33'(cmd_mag) * 33'(cfg.duty_per_speed);
	assign mot_rnd   = mot_prod + 33'd32768;
	assign mot_drive = duty_of(mot_rnd[31:16], ctrl.cmd[15], cfg.neutral_duty, cfg.duty_span);

	assign ang_mag   = ctrl.angle[5] ? 6'(-ctrl.angle) : ctrl.angle;
	assign srv_prod  = 22'(ang_mag) * 22'(cfg.angle_gain);
	assign srv_rnd   = srv_prod + 22'd128;
	assign srv_drive = duty_of({2'b00, srv_rnd[21:8]}, ctrl.angle[5], cfg.neutral_duty,
		cfg.duty_span);

	always_comb begin
		case (ctrl.mot_mode)
			DUTY_DRIVE:   mot_d = mot_drive;
			DUTY_NEUTRAL: mot_d = cfg.neutral_duty;
			default:      mot_d = motor_duty_q;
		endcase
		case (ctrl.srv_mode)
			DUTY_DRIVE:   srv_d = srv_drive;
			DUTY_NEUTRAL: srv_d = cfg.neutral_duty;
			default:      srv_d = servo_duty_q;
		endcase
	end

	// result register doubles as the held duty state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_duty_q     <= NEUTRAL_RESET;
			servo_duty_q     <= NEUTRAL_RESET;
			measured_speed_q <= '0;
		end else if (load) begin
			motor_duty_q     <= mot_d;
			servo_duty_q     <= srv_d;
			measured_speed_q <= ctrl.speed_seen;
		end
	end

endmodule

>>> hw/rtl/stepped_speed_regulator_pwm_core.sv
// a request passes the input, product, controller and result registers before m_axis
// throughput: one request per cycle unless m_axis_tready holds results back, four register stages
// no stall inside the datapath; the regulator state sits in one stage, read and written in the same cycle
// reset: controller state cleared, both duties held at 1500, measured speed 0,
// configuration registers back to their default values
module stepped_speed_regulator_pwm_core #(
	parameter int PULSE_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// input requests
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// target_speed, target_angle, pulse_count, stop_request (lowest bit first)
	input  logic [((20+PULSE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	// results
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// motor_duty, servo_duty, measured_speed (lowest bit first)
	output logic [sspr_pkg::OUT_W-1:0]               m_axis_tdata,
	// configuration writes
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [2:0]                               cfg_index,
	input  logic [15:0]                              cfg_data
);
	import sspr_pkg::*;

	// field positions in s_axis_tdata
	localparam int ANG_LO  = 13;
	localparam int PLS_LO  = 19;
	localparam int STOP_AT = 19 + PULSE_BITS;

	cfg_t cfg_q;

	// stage valids: input register, measured product, controller, result
	logic v_s1, v_s2, v_s3, v_out_q;
	logic rdy1, rdy2, rdy3, rdy_out;

	logic signed [12:0]    tgt_s1;
	logic signed [5:0]     ang_s1;
	logic [PULSE_BITS-1:0] pls_s1;
	logic                  stop_s1;

	meas_t meas_s2;
	ctrl_t ctrl_s3;

	logic [10:0]        motor_duty_q;
	logic [10:0]        servo_duty_q;
	logic signed [17:0] measured_speed_q;

	// each stage moves when the one below is empty or moving
	assign rdy_out       = !v_out_q || m_axis_tready;
	assign rdy3          = !v_s3 || rdy_out;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata  = {measured_speed_q, servo_duty_q, motor_duty_q};

	// configuration port, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_per_pulse <= 10'd322;
			cfg_q.duty_per_speed  <= 16'd3818;
			cfg_q.angle_gain      <= 16'd4267;
			cfg_q.cmd_inc         <= 11'd64;
			cfg_q.seen_tol        <= 11'd13;
			cfg_q.neutral_duty    <= 11'd1500;
			cfg_q.duty_span       <= 10'd500;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPEED_PER_PULSE: cfg_q.speed_per_pulse <= cfg_data[9:0];
				REG_DUTY_PER_SPEED:  cfg_q.duty_per_speed  <= cfg_data;
				REG_ANGLE_GAIN:      cfg_q.angle_gain      <= cfg_data;
				REG_CMD_INC:         cfg_q.cmd_inc         <= cfg_data[10:0];
				REG_SEEN_TOL:        cfg_q.seen_tol        <= cfg_data[10:0];
				REG_NEUTRAL_DUTY:    cfg_q.neutral_duty    <= cfg_data[10:0];
				REG_DUTY_SPAN:       cfg_q.duty_span       <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				v_out_q <= v_s3;
			end
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (rdy1) begin
			tgt_s1  <= $signed(s_axis_tdata[ANG_LO-1:0]);
			ang_s1  <= $signed(s_axis_tdata[PLS_LO-1:ANG_LO]);
			pls_s1  <= s_axis_tdata[STOP_AT-1:PLS_LO];
			stop_s1 <= s_axis_tdata[STOP_AT];
		end
	end

	// encoder pulses times speed per pulse
	sspr_meas #(
		.PULSE_BITS(PULSE_BITS)
	) u_meas (
		.clk            (clk),
		.load           (rdy2),
		.speed_per_pulse(cfg_q.speed_per_pulse),
		.target_speed   (tgt_s1),
		.target_angle   (ang_s1),
		.pulse_count    (pls_s1),
		.stop_request   (stop_s1),
		.meas_s2        (meas_s2)
	);

	// regulator state; updated only when a valid request moves into this stage
	sspr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (rdy3),
		.upd    (v_s2 && rdy3),
		.cfg    (cfg_q),
		.meas   (meas_s2),
		.ctrl_s3(ctrl_s3)
	);

	// duty scaling, clamping and the result register
	sspr_duty u_duty (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (v_s3 && rdy_out),
		.cfg             (cfg_q),
		.ctrl            (ctrl_s3),
		.motor_duty_q    (motor_duty_q),
		.servo_duty_q    (servo_duty_q),
		.measured_speed_q(measured_speed_q)
	);

endmodule

>>> hw/rtl/sspr_checker.sv
`include "stepped_speed_regulator_pwm_core_assert.svh"

module sspr_checker #(
	parameter int PULSE_BITS = 8
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [((20+PULSE_BITS+7)/8)*8-1:0] s_axis_tdata,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [sspr_pkg::OUT_W-1:0]         m_axis_tdata,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [2:0]                         cfg_index,
	input logic [15:0]                        cfg_data
);
	import sspr_pkg::*;

	logic       in_acc, out_acc;
	logic [2:0] inflight_q;
	logic       last_stop_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// requests inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			last_stop_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
			if (in_acc) begin
				last_stop_q <= s_axis_tdata[19+PULSE_BITS];
			end
		end
	end

	`SSPR_ASSERT_NOW(a_no_phantom, m_axis_tvalid, inflight_q != 3'd0, "result with no request")
	`SSPR_ASSERT_NOW(a_depth, 1'b1, inflight_q <= 3'd4, "more requests in flight than stages")
	`SSPR_ASSERT_NOW(a_stop_neutral, out_acc && (inflight_q == 3'd1) && last_stop_q,
		(m_axis_tdata[39:22] == 18'd0) && (m_axis_tdata[10:0] == m_axis_tdata[21:11]),
		"stop did not return to neutral")
	`SSPR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind stepped_speed_regulator_pwm_core sspr_checker #(.PULSE_BITS(PULSE_BITS)) u_sspr_checker (.*);
